/* src/tspe_pkg.sv */
// ============================================================================
// tspe_pkg : shared types and constants of the time switch program evaluator
// Field layouts of the stream words, slot and timer records, action codes and
// the command/status bundles between controller and datapath.
// ============================================================================
package tspe_pkg;

  // Default sizes
  localparam int DEF_NUM_TIMERS   = 16;
  localparam int DEF_NUM_PROGRAMS = 8;
  localparam int DEF_NUM_OUTPUTS  = 20;

  // Field widths
  localparam int ACT_W  = 2;
  localparam int TIDX_W = 4;
  localparam int PIDX_W = 3;
  localparam int DAY_W  = 5;
  localparam int SEC_W  = 17;
  localparam int OUT_W  = 5;
  localparam int TNUM_W = 4;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 16;

  // Seconds in one day, one bit wider than a time of day
  localparam logic [SEC_W:0] DAY_SECONDS = 18'd86400;

  typedef enum logic [ACT_W-1:0] {
    ACT_EVAL     = 2'd0,
    ACT_NORMAL   = 2'd1,
    ACT_DAILY    = 2'd2,
    ACT_SETTINGS = 2'd3
  } act_t;

  // Input word, lowest field last
  typedef struct packed {
    logic [SEC_W-1:0]  run_length;
    logic              daily_mode;
    logic [OUT_W-1:0]  out_number;
    logic [SEC_W-1:0]  off_seconds;
    logic [SEC_W-1:0]  seconds_value;
    logic [DAY_W-1:0]  stop_day;
    logic [DAY_W-1:0]  day_value;
    logic              program_enable;
    logic [PIDX_W-1:0] program_index;
    logic [TIDX_W-1:0] timer_index;
  } in_item_t;

  localparam int IN_ITEM_W = $bits(in_item_t);

  typedef struct packed {
    logic              output_on;
    logic [OUT_W-1:0]  output_number;
    logic [TNUM_W-1:0] timer_number;
  } result_t;

  localparam int RES_W = $bits(result_t);

  typedef struct packed {
    logic             en;
    logic [DAY_W-1:0] start_day;
    logic [DAY_W-1:0] stop_day;
    logic [SEC_W-1:0] on_time;
    logic [SEC_W-1:0] stop_time;
  } normal_slot_t;

  typedef struct packed {
    logic             en;
    logic [SEC_W-1:0] on_time;
  } daily_slot_t;

  typedef struct packed {
    logic [OUT_W-1:0] out;
    logic             daily;
    logic [SEC_W-1:0] run;
  } timer_cfg_t;

  localparam int NRM_W = $bits(normal_slot_t);
  localparam int DLY_W = $bits(daily_slot_t);
  localparam int CFG_W = $bits(timer_cfg_t);

  // Controller to datapath
  typedef struct packed {
    logic clr_wr;   // clearing pass write
    logic wr_item;  // accepted write word
    logic ld_time;  // latch day and second of an evaluate word
    logic cfg_ld;   // latch settings of an assigned timer
    logic slot_rd;  // slot read issued this cycle
    logic push;     // finished timer result into pending register
    logic flush;    // pending result out as the final one
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic assigned;
    logic out_free;
    logic pend_vld;
  } dp_sts_t;

endpackage

/* src/tspe_ram.sv */
// ============================================================================
// tspe_ram : generic single write port RAM
// One write and one read address per cycle, read data registered.
// ============================================================================
module tspe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/tspe_ctrl.sv */
// ============================================================================
// tspe_ctrl : sequencer of the time switch program evaluator
// Runs the clearing pass, takes words, and walks timers and slots for an
// evaluation, issuing commands to the datapath.
// ============================================================================
module tspe_ctrl #(
  parameter int NUM_TIMERS   = tspe_pkg::DEF_NUM_TIMERS,
  parameter int NUM_PROGRAMS = tspe_pkg::DEF_NUM_PROGRAMS,
  localparam int TW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1,
  localparam int PW = (NUM_PROGRAMS > 1) ? $clog2(NUM_PROGRAMS) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic [tspe_pkg::ACT_W-1:0] in_tuser,
  output logic                       in_tready,
  input  tspe_pkg::dp_sts_t          sts,
  output tspe_pkg::ctl_cmd_t         cmd,
  output logic [TW-1:0]              t_idx,
  output logic [PW-1:0]              p_idx,
  output logic [TW+PW-1:0]           clr_idx
);

  import tspe_pkg::*;

  localparam int SAW        = TW + PW;
  localparam int SLOT_DEPTH = NUM_TIMERS * (1 << PW);

  localparam logic [SAW-1:0] CLR_LAST = SAW'(SLOT_DEPTH - 1);
  localparam logic [TW-1:0]  T_LAST   = TW'(NUM_TIMERS - 1);
  localparam logic [PW-1:0]  P_LAST   = PW'(NUM_PROGRAMS - 1);

  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_CFG_RD  = 7'b0000100,
    S_CFG_CHK = 7'b0001000,
    S_SCAN    = 7'b0010000,
    S_PUSH    = 7'b0100000,
    S_FLUSH   = 7'b1000000
  } state_t;

  state_t         state_r, state_nxt;
  logic [TW-1:0]  t_r, t_nxt;
  logic [PW-1:0]  p_r, p_nxt;
  logic [SAW-1:0] clr_r, clr_nxt;

  always_comb begin
    state_nxt = state_r;
    t_nxt     = t_r;
    p_nxt     = p_r;
    clr_nxt   = clr_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (act_t'(in_tuser) == ACT_EVAL) begin
            cmd.ld_time = 1'b1;
            t_nxt       = '0;
            state_nxt   = S_CFG_RD;
          end else begin
            cmd.wr_item = 1'b1;
          end
        end
      end
      S_CFG_RD: begin
        state_nxt = S_CFG_CHK;
      end
      S_CFG_CHK: begin
        if (sts.assigned) begin
          cmd.cfg_ld = 1'b1;
          p_nxt      = '0;
          state_nxt  = S_SCAN;
        end else if (t_r == T_LAST) begin
          state_nxt = S_FLUSH;
        end else begin
          t_nxt     = t_r + 1'b1;
          state_nxt = S_CFG_RD;
        end
      end
      S_SCAN: begin
        cmd.slot_rd = 1'b1;
        if (p_r == P_LAST) begin
          state_nxt = S_PUSH;
        end else begin
          p_nxt = p_r + 1'b1;
        end
      end
      S_PUSH: begin
        // hold while the older result cannot move on
        if (!sts.pend_vld || sts.out_free) begin
          cmd.push = 1'b1;
          if (t_r == T_LAST) begin
            state_nxt = S_FLUSH;
          end else begin
            t_nxt     = t_r + 1'b1;
            state_nxt = S_CFG_RD;
          end
        end
      end
      S_FLUSH: begin
        if (!sts.pend_vld) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      t_r     <= '0;
      p_r     <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      t_r     <= t_nxt;
      p_r     <= p_nxt;
      clr_r   <= clr_nxt;
    end
  end

  assign t_idx   = t_r;
  assign p_idx   = p_r;
  assign clr_idx = clr_r;

  a_clear_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> !in_tready)
    else $error("word taken during clearing pass");

  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH && state_nxt == S_IDLE) |=> !sts.pend_vld)
    else $error("pending result left behind at end of evaluation");

  a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && p_r == '0) |-> $past(state_r) == S_CFG_CHK)
    else $error("slot scan started without timer settings");

endmodule

/* src/tspe_dp.sv */
// ============================================================================
// tspe_dp : datapath of the time switch program evaluator
// Slot and settings RAMs, slot window checks, the pending result and the
// output register.
// ============================================================================
module tspe_dp #(
  parameter int NUM_TIMERS   = tspe_pkg::DEF_NUM_TIMERS,
  parameter int NUM_PROGRAMS = tspe_pkg::DEF_NUM_PROGRAMS,
  parameter int NUM_OUTPUTS  = tspe_pkg::DEF_NUM_OUTPUTS,
  localparam int TW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1,
  localparam int PW = (NUM_PROGRAMS > 1) ? $clog2(NUM_PROGRAMS) : 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tspe_pkg::ctl_cmd_t               cmd,
  input  logic [TW-1:0]                    t_idx,
  input  logic [PW-1:0]                    p_idx,
  input  logic [TW+PW-1:0]                 clr_idx,
  input  logic [tspe_pkg::ACT_W-1:0]       in_tuser,
  input  logic [tspe_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             out_tready,
  output tspe_pkg::dp_sts_t                sts,
  output logic                             out_tvalid,
  output logic [tspe_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast
);

  import tspe_pkg::*;

  localparam int SAW        = TW + PW;
  localparam int SLOT_DEPTH = NUM_TIMERS * (1 << PW);

  function automatic logic normal_active(normal_slot_t s, logic [DAY_W-1:0] day,
                                         logic [SEC_W-1:0] t);
    logic r;
    if (s.start_day == s.stop_day && s.on_time == s.stop_time) begin
      r = 1'b0;
    end else if (day < s.start_day) begin
      r = 1'b0;
    end else if (day == s.start_day) begin
      r = !(s.start_day == s.stop_day && t > s.stop_time) && (t >= s.on_time);
    end else if (day < s.stop_day) begin
      r = 1'b1;
    end else if (day == s.stop_day) begin
      r = t < s.stop_time;
    end else begin
      r = 1'b0;
    end
    return r;
  endfunction

  function automatic logic daily_active(logic [SEC_W-1:0] on, logic [SEC_W-1:0] run,
                                        logic [SEC_W-1:0] t);
    logic [SEC_W:0] sum;
    logic [SEC_W:0] fin;
    logic           r;
    sum = {1'b0, on} + {1'b0, run};
    // wrap past midnight once
    fin = (sum > DAY_SECONDS) ? sum - DAY_SECONDS : sum;
    if (fin >= {1'b0, on}) begin
      r = (t >= on) && ({1'b0, t} < fin);
    end else begin
      r = (t >= on) || ({1'b0, t} < fin);
    end
    return r;
  endfunction

  in_item_t item;
  act_t     act;
  logic     ti_ok, pi_ok;

  assign item  = in_item_t'(in_tdata[IN_ITEM_W-1:0]);
  assign act   = act_t'(in_tuser);
  assign ti_ok = int'(item.timer_index) < NUM_TIMERS;
  assign pi_ok = int'(item.program_index) < NUM_PROGRAMS;

  // --------------------------------------------------------------------------
  // Storage
  // --------------------------------------------------------------------------
  logic             cfg_we, nrm_we, dly_we;
  logic [TW-1:0]    cfg_waddr;
  logic [SAW-1:0]   slot_waddr, slot_raddr;
  timer_cfg_t       cfg_wdata, cfg_rdata;
  normal_slot_t     nrm_wdata, nrm_rdata;
  daily_slot_t      dly_wdata, dly_rdata;
  logic [CFG_W-1:0] cfg_rvec;
  logic [NRM_W-1:0] nrm_rvec;
  logic [DLY_W-1:0] dly_rvec;

  assign cfg_we = cmd.clr_wr || (cmd.wr_item && act == ACT_SETTINGS && ti_ok);
  assign nrm_we = cmd.clr_wr || (cmd.wr_item && act == ACT_NORMAL && ti_ok && pi_ok);
  assign dly_we = cmd.clr_wr || (cmd.wr_item && act == ACT_DAILY && ti_ok && pi_ok);

  assign cfg_waddr  = cmd.clr_wr ? clr_idx[SAW-1:PW] : TW'(item.timer_index);
  assign slot_waddr = cmd.clr_wr ? clr_idx
                                 : {TW'(item.timer_index), PW'(item.program_index)};
  assign slot_raddr = {t_idx, p_idx};

  always_comb begin
    if (cmd.clr_wr) begin
      cfg_wdata = '{out: OUT_W'(NUM_OUTPUTS), daily: 1'b0, run: '0};
      nrm_wdata = '{en: 1'b0, start_day: DAY_W'(1), stop_day: DAY_W'(1),
                    on_time: '0, stop_time: '0};
      dly_wdata = '{en: 1'b0, on_time: '0};
    end else begin
      cfg_wdata = '{out: item.out_number, daily: item.daily_mode, run: item.run_length};
      nrm_wdata = '{en: item.program_enable, start_day: item.day_value,
                    stop_day: item.stop_day, on_time: item.seconds_value,
                    stop_time: item.off_seconds};
      dly_wdata = '{en: item.program_enable, on_time: item.seconds_value};
    end
  end

  tspe_ram #(.WIDTH(CFG_W), .DEPTH(NUM_TIMERS)) u_cfg_ram (
    .clk   (clk),
    .we    (cfg_we),
    .waddr (cfg_waddr),
    .wdata (CFG_W'(cfg_wdata)),
    .raddr (t_idx),
    .rdata (cfg_rvec)
  );

  tspe_ram #(.WIDTH(NRM_W), .DEPTH(SLOT_DEPTH)) u_nrm_ram (
    .clk   (clk),
    .we    (nrm_we),
    .waddr (slot_waddr),
    .wdata (NRM_W'(nrm_wdata)),
    .raddr (slot_raddr),
    .rdata (nrm_rvec)
  );

  tspe_ram #(.WIDTH(DLY_W), .DEPTH(SLOT_DEPTH)) u_dly_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (slot_waddr),
    .wdata (DLY_W'(dly_wdata)),
    .raddr (slot_raddr),
    .rdata (dly_rvec)
  );

  assign cfg_rdata = timer_cfg_t'(cfg_rvec);
  assign nrm_rdata = normal_slot_t'(nrm_rvec);
  assign dly_rdata = daily_slot_t'(dly_rvec);

  // --------------------------------------------------------------------------
  // Slot evaluation
  // --------------------------------------------------------------------------
  logic [DAY_W-1:0] day_r;
  logic [SEC_W-1:0] sec_r;
  timer_cfg_t       cfg_r;
  logic             on_r;
  logic             evl_vld_r, evl_vld_nxt;
  logic             hit, on_final;

  assign hit = cfg_r.daily ? (dly_rdata.en && daily_active(dly_rdata.on_time, cfg_r.run, sec_r))
                           : (nrm_rdata.en && normal_active(nrm_rdata, day_r, sec_r));
  assign on_final    = on_r || (evl_vld_r && hit);
  assign evl_vld_nxt = cmd.slot_rd;

  always_ff @(posedge clk) begin
    if (cmd.ld_time) begin
      day_r <= item.day_value;
      sec_r <= item.seconds_value;
    end
    if (cmd.cfg_ld) begin
      cfg_r <= cfg_rdata;
      on_r  <= 1'b0;
    end else begin
      on_r  <= on_final;
    end
  end

  // --------------------------------------------------------------------------
  // Pending result and output register
  // --------------------------------------------------------------------------
  logic [TW-1:0]    pend_t_r;
  logic [OUT_W-1:0] pend_onum_r;
  logic             pend_on_r;
  logic             pend_vld_r, pend_vld_nxt;
  result_t          out_res_r;
  logic             out_last_r;
  logic             out_vld_r, out_vld_nxt;
  logic             out_free, out_load;

  assign out_free = !out_vld_r || out_tready;
  // a newer result proves the pending one is not the last
  assign out_load = (cmd.push && pend_vld_r) || cmd.flush;

  always_comb begin
    pend_vld_nxt = pend_vld_r;
    if (cmd.push) begin
      pend_vld_nxt = 1'b1;
    end else if (cmd.flush) begin
      pend_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      pend_t_r    <= t_idx;
      pend_onum_r <= cfg_r.out;
      pend_on_r   <= on_final;
    end
    if (out_load) begin
      out_res_r  <= '{output_on: pend_on_r, output_number: pend_onum_r,
                      timer_number: TNUM_W'(pend_t_r)};
      out_last_r <= cmd.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evl_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      evl_vld_r  <= evl_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  assign sts = '{assigned: (int'(cfg_rdata.out) < NUM_OUTPUTS),
                 out_free: out_free,
                 pend_vld: pend_vld_r};

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, out_res_r};
  assign out_tlast  = out_last_r;

  a_push_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && pend_vld_r) |-> out_free)
    else $error("pending result pushed over a stalled output word");

  a_flush_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |-> (pend_vld_r && out_free))
    else $error("final result flushed without pending data or room");

  a_flush_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> (out_vld_r && out_last_r && !pend_vld_r))
    else $error("final result not marked last");

endmodule

/* src/time_switch_program_evaluator.sv */
// ============================================================================
// time_switch_program_evaluator : programmable time switch evaluator
// Holds per-timer settings and program slots; an evaluate word yields one
// output state word for every assigned timer, in timer order.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+----------------------------------
//   in_     | in  | in_tvalid / in_tready  | tuser action, tdata write/eval
//   out_    | out | out_tvalid / out_tready| tdata result, tlast final result
//
// After reset a clearing pass writes every slot address, and with it the
// settings of every timer, before the first word is taken.
// A write word is stored as it is taken. An evaluate word reads the settings
// of each timer in turn and, for an assigned timer, its NUM_PROGRAMS slots
// through the single read port of the slot RAMs, one slot a cycle.
// A stalled output holds the walk when a second result is ready, and holds
// the end of an evaluation until the final result reaches the output
// register; the next word is taken while the last result still waits.
// ============================================================================
module time_switch_program_evaluator #(
  parameter int NUM_TIMERS   = tspe_pkg::DEF_NUM_TIMERS,
  parameter int NUM_PROGRAMS = tspe_pkg::DEF_NUM_PROGRAMS,
  parameter int NUM_OUTPUTS  = tspe_pkg::DEF_NUM_OUTPUTS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tuser: action[1:0]
  input  logic [tspe_pkg::ACT_W-1:0]       in_tuser,
  // tdata: timer_index[3:0], program_index[6:4], program_enable[7],
  //        day_value[12:8], stop_day[17:13], seconds_value[34:18],
  //        off_seconds[51:35], out_number[56:52], daily_mode[57],
  //        run_length[74:58], zero[79:75]
  input  logic [tspe_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata: timer_number[3:0], output_number[8:4], output_on[9], zero[15:10]
  output logic [tspe_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast
);

  import tspe_pkg::*;

  localparam int TW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int PW = (NUM_PROGRAMS > 1) ? $clog2(NUM_PROGRAMS) : 1;

  ctl_cmd_t        cmd;
  dp_sts_t         sts;
  logic [TW-1:0]   t_idx;
  logic [PW-1:0]   p_idx;
  logic [TW+PW-1:0] clr_idx;

  tspe_ctrl #(
    .NUM_TIMERS   (NUM_TIMERS),
    .NUM_PROGRAMS (NUM_PROGRAMS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd),
    .t_idx     (t_idx),
    .p_idx     (p_idx),
    .clr_idx   (clr_idx)
  );

  tspe_dp #(
    .NUM_TIMERS   (NUM_TIMERS),
    .NUM_PROGRAMS (NUM_PROGRAMS),
    .NUM_OUTPUTS  (NUM_OUTPUTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .t_idx      (t_idx),
    .p_idx      (p_idx),
    .clr_idx    (clr_idx),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
